// File: rtl/tbc_pkg.sv
`default_nettype none
// ============================================================================
// tbc_pkg
// Shared types, widths and constants for the eased tween unit.
// ============================================================================
package tbc_pkg;

    // Fixed-point and time widths
    localparam int FRAC_BITS  = 16;
    localparam int TIME_BITS  = 16;
    localparam int XW         = FRAC_BITS + 1;     // ratio / curve value, holds 1.0
    localparam int DW         = FRAC_BITS + 4;     // bounce distance |22x - k|
    localparam int PW         = FRAC_BITS + 6;     // 22x and 11x
    localparam int MW         = 32 + XW;           // |delta| * v
    localparam int DIV_STAGES = FRAC_BITS + 1;     // one quotient bit per stage

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [XW-1:0]        t_ratio;
    typedef logic [DW-1:0]        t_dist;
    typedef logic [PW-1:0]        t_bpos;
    typedef logic [2*XW-1:0]      t_sq;
    typedef logic [2*DW-1:0]      t_dd;
    typedef logic [MW-1:0]        t_mprod;
    typedef logic [31:0]          t_word;
    typedef logic [33:0]          t_wide;

    localparam t_ratio ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] ROUND_UP = {FRAC_BITS{1'b1}};

    // Curve codes
    localparam logic [2:0] CRV_CUBIC_IN   = 3'd1;
    localparam logic [2:0] CRV_CUBIC_OUT  = 3'd2;
    localparam logic [2:0] CRV_QUAD_IN    = 3'd3;
    localparam logic [2:0] CRV_QUAD_OUT   = 3'd4;
    localparam logic [2:0] CRV_BOUNCE_OUT = 3'd5;

    // Bounce-out segment edges (compared against 11x)
    localparam t_bpos BNC_EDGE1 = t_bpos'(4)  << FRAC_BITS;
    localparam t_bpos BNC_EDGE2 = t_bpos'(8)  << FRAC_BITS;
    localparam t_bpos BNC_EDGE3 = t_bpos'(10) << FRAC_BITS;
    // Segment centers (in units of 22x)
    localparam t_bpos BNC_K1 = t_bpos'(12) << FRAC_BITS;
    localparam t_bpos BNC_K2 = t_bpos'(18) << FRAC_BITS;
    localparam t_bpos BNC_K3 = t_bpos'(21) << FRAC_BITS;
    // Segment offsets 3/4, 15/16, 63/64
    localparam t_ratio BNC_C1 = t_ratio'(3)  << (FRAC_BITS - 2);
    localparam t_ratio BNC_C2 = t_ratio'(15) << (FRAC_BITS - 4);
    localparam t_ratio BNC_C3 = t_ratio'(63) << (FRAC_BITS - 6);

    localparam t_word POS_MAX = 32'h7FFF_FFFF;
    localparam t_word POS_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic [15:0]        elapsed;
        logic [15:0]        duration;
        logic [2:0]         command;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               ratio_clamped;
    } t_out_item;

    // Per-axis geometry carried down the pipe: start, sign and |end - start|
    typedef struct packed {
        logic [2:0][31:0] start;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } t_geom;

endpackage
`default_nettype wire

// File: rtl/tbc_div.sv
`default_nettype none
// ============================================================================
// tbc_div
// Pipelined restoring divider: ratio = elapsed * ONE / duration, one
// quotient bit per stage, with the clamp to 1.0 applied at the last stage.
// ============================================================================
module tbc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tbc_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tbc_pkg::t_ratio        o_x,
    output logic                   o_clamped,
    output logic [2:0]             o_command,
    output tbc_pkg::t_geom         o_geom
);

    logic                 r_v     [tbc_pkg::DIV_STAGES];
    tbc_pkg::t_time       r_rem   [tbc_pkg::DIV_STAGES];
    tbc_pkg::t_time       r_du    [tbc_pkg::DIV_STAGES];
    tbc_pkg::t_ratio      r_q     [tbc_pkg::DIV_STAGES];
    logic                 r_clamp [tbc_pkg::DIV_STAGES];
    logic [2:0]           r_cmd   [tbc_pkg::DIV_STAGES];
    tbc_pkg::t_geom       r_geom  [tbc_pkg::DIV_STAGES];
    logic [tbc_pkg::DIV_STAGES:0] w_rdy;

    assign w_rdy[tbc_pkg::DIV_STAGES] = i_ready;
    assign o_ready = w_rdy[0];

    for (genvar k = 0; k < tbc_pkg::DIV_STAGES; k++) begin : g_stage
        logic            n_v;
        tbc_pkg::t_time  n_rem;
        tbc_pkg::t_time  n_du;
        tbc_pkg::t_ratio n_q;
        logic            n_clamp;
        logic [2:0]      n_cmd;
        tbc_pkg::t_geom  n_geom;

        // a stage takes new contents when it is empty or its contents move on
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        if (k == 0) begin : g_first
            tbc_pkg::t_time  w_el;
            tbc_pkg::t_time  w_du;
            logic [2:0][32:0] w_span;
            logic             w_ge;

            always_comb begin
                w_el      = tbc_pkg::t_time'(i_item.elapsed);
                w_du      = tbc_pkg::t_time'(i_item.duration);
                w_ge      = (w_el >= w_du);
                w_span[0] = {i_item.end_x[31], i_item.end_x}
                          - {i_item.start_x[31], i_item.start_x};
                w_span[1] = {i_item.end_y[31], i_item.end_y}
                          - {i_item.start_y[31], i_item.start_y};
                w_span[2] = {i_item.end_z[31], i_item.end_z}
                          - {i_item.start_z[31], i_item.start_z};

                n_v     = i_valid;
                n_du    = w_du;
                n_clamp = (w_du == '0) || (w_el > w_du);
                // integer bit of the quotient; elapsed <= duration otherwise clamped
                n_q     = w_ge ? tbc_pkg::t_ratio'(1) : '0;
                n_rem   = w_ge ? (w_el - w_du) : w_el;
                n_cmd   = i_item.command;
                n_geom.start[0] = i_item.start_x;
                n_geom.start[1] = i_item.start_y;
                n_geom.start[2] = i_item.start_z;
                // mag holds the raw two's-complement span until stage 1
                for (int a = 0; a < 3; a++) begin
                    n_geom.neg[a] = w_span[a][32];
                    n_geom.mag[a] = w_span[a][31:0];
                end
            end
        end else begin : g_step
            logic [tbc_pkg::TIME_BITS:0] w_two;
            logic [tbc_pkg::TIME_BITS:0] w_dx;
            logic                        w_ge;

            always_comb begin
                w_two   = {r_rem[k-1], 1'b0};
                w_dx    = {1'b0, r_du[k-1]};
                w_ge    = (w_two >= w_dx);
                n_v     = r_v[k-1];
                n_du    = r_du[k-1];
                n_clamp = r_clamp[k-1];
                n_cmd   = r_cmd[k-1];
                n_rem   = w_ge ? tbc_pkg::t_time'(w_two - w_dx) : tbc_pkg::t_time'(w_two);
                if ((k == tbc_pkg::DIV_STAGES - 1) && r_clamp[k-1]) begin
                    n_q = tbc_pkg::ONE;
                end else begin
                    n_q = {r_q[k-1][tbc_pkg::XW-2:0], w_ge};
                end
                n_geom = r_geom[k-1];
                if (k == 1) begin
                    for (int a = 0; a < 3; a++) begin
                        if (r_geom[k-1].neg[a]) begin
                            n_geom.mag[a] = ~r_geom[k-1].mag[a] + 32'd1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= n_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]   <= n_rem;
                r_du[k]    <= n_du;
                r_q[k]     <= n_q;
                r_clamp[k] <= n_clamp;
                r_cmd[k]   <= n_cmd;
                r_geom[k]  <= n_geom;
            end
        end
    end

    assign o_valid   = r_v[tbc_pkg::DIV_STAGES-1];
    assign o_x       = r_q[tbc_pkg::DIV_STAGES-1];
    assign o_clamped = r_clamp[tbc_pkg::DIV_STAGES-1];
    assign o_command = r_cmd[tbc_pkg::DIV_STAGES-1];
    assign o_geom    = r_geom[tbc_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/tbc_curve.sv
`default_nettype none
// ============================================================================
// tbc_curve
// Four-stage easing curve: operand prep, square, cube/bounce, select.
// ============================================================================
module tbc_curve (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tbc_pkg::t_ratio i_x,
    input  wire logic            i_clamped,
    input  wire logic [2:0]      i_command,
    input  wire tbc_pkg::t_geom  i_geom,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tbc_pkg::t_ratio      o_v,
    output logic                 o_clamped,
    output tbc_pkg::t_geom       o_geom
);

    logic [3:0] r_v;
    logic [4:0] w_rdy;

    // stage 0: mirrored operand, bounce distance and offset
    tbc_pkg::t_ratio r0_a, r0_c;
    tbc_pkg::t_dist  r0_d;
    logic [2:0]      r0_cmd;
    logic            r0_clamp;
    tbc_pkg::t_geom  r0_geom;
    // stage 1: squares
    tbc_pkg::t_sq    r1_sq2;
    tbc_pkg::t_dd    r1_dd;
    tbc_pkg::t_ratio r1_a, r1_c;
    logic [2:0]      r1_cmd;
    logic            r1_clamp;
    tbc_pkg::t_geom  r1_geom;
    // stage 2: cube product, square, bounce value
    tbc_pkg::t_sq    r2_cube3;
    tbc_pkg::t_ratio r2_sq, r2_bnc;
    logic [2:0]      r2_cmd;
    logic            r2_clamp;
    tbc_pkg::t_geom  r2_geom;
    // stage 3: curve value
    tbc_pkg::t_ratio r3_v;
    logic            r3_clamp;
    tbc_pkg::t_geom  r3_geom;

    tbc_pkg::t_ratio n0_a, n0_c;
    tbc_pkg::t_dist  n0_d;
    tbc_pkg::t_bpos  w_x11, w_p, w_k;
    tbc_pkg::t_sq    n1_sq2;
    tbc_pkg::t_dd    n1_dd;
    tbc_pkg::t_ratio w_sq, n2_bnc;
    tbc_pkg::t_sq    n2_cube3;
    tbc_pkg::t_ratio w_cube, n3_v;

    assign w_rdy[4] = i_ready;
    for (genvar k = 0; k < 4; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    always_comb begin
        if (i_command inside {tbc_pkg::CRV_CUBIC_OUT, tbc_pkg::CRV_QUAD_OUT}) begin
            n0_a = tbc_pkg::ONE - i_x;
        end else begin
            n0_a = i_x;
        end
        w_x11 = tbc_pkg::t_bpos'(i_x) * tbc_pkg::t_bpos'(11);
        w_p   = tbc_pkg::t_bpos'(i_x) * tbc_pkg::t_bpos'(22);
        if (w_x11 < tbc_pkg::BNC_EDGE1) begin
            w_k  = '0;
            n0_c = '0;
        end else if (w_x11 < tbc_pkg::BNC_EDGE2) begin
            w_k  = tbc_pkg::BNC_K1;
            n0_c = tbc_pkg::BNC_C1;
        end else if (w_x11 < tbc_pkg::BNC_EDGE3) begin
            w_k  = tbc_pkg::BNC_K2;
            n0_c = tbc_pkg::BNC_C2;
        end else begin
            w_k  = tbc_pkg::BNC_K3;
            n0_c = tbc_pkg::BNC_C3;
        end
        n0_d = tbc_pkg::t_dist'((w_p >= w_k) ? (w_p - w_k) : (w_k - w_p));
    end

    assign n1_sq2 = tbc_pkg::t_sq'(r0_a) * tbc_pkg::t_sq'(r0_a);
    assign n1_dd  = tbc_pkg::t_dd'(r0_d) * tbc_pkg::t_dd'(r0_d);

    assign w_sq     = tbc_pkg::t_ratio'(r1_sq2 >> tbc_pkg::FRAC_BITS);
    assign n2_cube3 = tbc_pkg::t_sq'(w_sq) * tbc_pkg::t_sq'(r1_a);
    assign n2_bnc   = tbc_pkg::t_ratio'(r1_dd >> (tbc_pkg::FRAC_BITS + 6)) + r1_c;

    assign w_cube = tbc_pkg::t_ratio'(r2_cube3 >> tbc_pkg::FRAC_BITS);
    always_comb begin
        case (r2_cmd)
            tbc_pkg::CRV_CUBIC_IN:   n3_v = w_cube;
            tbc_pkg::CRV_CUBIC_OUT:  n3_v = tbc_pkg::ONE - w_cube;
            tbc_pkg::CRV_QUAD_IN:    n3_v = r2_sq;
            tbc_pkg::CRV_QUAD_OUT:   n3_v = tbc_pkg::ONE - r2_sq;
            tbc_pkg::CRV_BOUNCE_OUT: n3_v = r2_bnc;
            default:                 n3_v = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_a     <= n0_a;
            r0_c     <= n0_c;
            r0_d     <= n0_d;
            r0_cmd   <= i_command;
            r0_clamp <= i_clamped;
            r0_geom  <= i_geom;
        end
        if (w_rdy[1]) begin
            r1_sq2   <= n1_sq2;
            r1_dd    <= n1_dd;
            r1_a     <= r0_a;
            r1_c     <= r0_c;
            r1_cmd   <= r0_cmd;
            r1_clamp <= r0_clamp;
            r1_geom  <= r0_geom;
        end
        if (w_rdy[2]) begin
            r2_cube3 <= n2_cube3;
            r2_sq    <= w_sq;
            r2_bnc   <= n2_bnc;
            r2_cmd   <= r1_cmd;
            r2_clamp <= r1_clamp;
            r2_geom  <= r1_geom;
        end
        if (w_rdy[3]) begin
            r3_v     <= n3_v;
            r3_clamp <= r2_clamp;
            r3_geom  <= r2_geom;
        end
    end

    assign o_valid   = r_v[3];
    assign o_v       = r3_v;
    assign o_clamped = r3_clamp;
    assign o_geom    = r3_geom;

endmodule
`default_nettype wire

// File: rtl/tbc_lerp.sv
`default_nettype none
// ============================================================================
// tbc_lerp
// Three-lane interpolation: |delta| * v, floor toward minus infinity,
// add start and saturate to signed 32 bits.
// ============================================================================
module tbc_lerp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tbc_pkg::t_ratio i_v,
    input  wire logic            i_clamped,
    input  wire tbc_pkg::t_geom  i_geom,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tbc_pkg::t_out_item   o_item
);

    logic [2:0] r_v;
    logic [3:0] w_rdy;

    tbc_pkg::t_mprod r0_prod [3];
    logic [2:0]      r0_neg;
    tbc_pkg::t_word  r0_start [3];
    logic            r0_clamp;

    tbc_pkg::t_word  r1_qmag [3];
    logic [2:0]      r1_neg;
    tbc_pkg::t_word  r1_start [3];
    logic            r1_clamp;

    tbc_pkg::t_word  r2_pos [3];
    logic            r2_clamp;

    tbc_pkg::t_mprod n0_prod [3];
    tbc_pkg::t_mprod w_rnd [3];
    tbc_pkg::t_word  n1_qmag [3];
    tbc_pkg::t_wide  w_sum [3];
    tbc_pkg::t_word  n2_pos [3];

    assign w_rdy[3] = i_ready;
    for (genvar k = 0; k < 3; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end
    assign o_ready = w_rdy[0];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n0_prod[a] = tbc_pkg::t_mprod'(i_geom.mag[a]) * tbc_pkg::t_mprod'(i_v);
            // negative span: ceil of the magnitude gives floor of the signed value
            w_rnd[a]   = r0_prod[a]
                       + (r0_neg[a] ? tbc_pkg::t_mprod'(tbc_pkg::ROUND_UP) : '0);
            n1_qmag[a] = tbc_pkg::t_word'(w_rnd[a] >> tbc_pkg::FRAC_BITS);
            if (r1_neg[a]) begin
                w_sum[a] = {{2{r1_start[a][31]}}, r1_start[a]} - {2'b00, r1_qmag[a]};
            end else begin
                w_sum[a] = {{2{r1_start[a][31]}}, r1_start[a]} + {2'b00, r1_qmag[a]};
            end
            if (w_sum[a][33] && (w_sum[a][32:31] != 2'b11)) begin
                n2_pos[a] = tbc_pkg::POS_MIN;
            end else if (!w_sum[a][33] && (w_sum[a][32:31] != 2'b00)) begin
                n2_pos[a] = tbc_pkg::POS_MAX;
            end else begin
                n2_pos[a] = w_sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_prod  <= n0_prod;
            r0_neg   <= i_geom.neg;
            for (int a = 0; a < 3; a++) begin
                r0_start[a] <= i_geom.start[a];
            end
            r0_clamp <= i_clamped;
        end
        if (w_rdy[1]) begin
            r1_qmag  <= n1_qmag;
            r1_neg   <= r0_neg;
            r1_start <= r0_start;
            r1_clamp <= r0_clamp;
        end
        if (w_rdy[2]) begin
            r2_pos   <= n2_pos;
            r2_clamp <= r1_clamp;
        end
    end

    assign o_valid              = r_v[2];
    assign o_item.pos_x         = r2_pos[0];
    assign o_item.pos_y         = r2_pos[1];
    assign o_item.pos_z         = r2_pos[2];
    assign o_item.ratio_clamped = r2_clamp;

endmodule
`default_nettype wire

// File: rtl/eased_tween_by_curve_unit.sv
`default_nettype none
// ============================================================================
// eased_tween_by_curve_unit
// Three-axis tween: progress ratio, easing curve, saturated interpolation.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------
//  input   | in        | i_valid / o_stall  | i_item (t_in_item)
//  result  | out       | o_valid / i_stall  | o_item (t_out_item)
//
//  The pipe has FRAC_BITS + 1 divider stages (one quotient bit each),
//  4 curve stages and 3 lerp stages. One item is accepted per cycle
//  while the result side does not stall. Reset (synchronous, active
//  low) clears only the stage valid bits. A stall from the result side
//  fills empty stages first; o_stall rises only once every stage holds
//  an item, and held items never change.
//
module eased_tween_by_curve_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire tbc_pkg::t_in_item i_item,
    // result item channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output tbc_pkg::t_out_item     o_item
);

    // divider -> curve
    logic            w_div_valid;
    logic            w_div_ready;
    tbc_pkg::t_ratio w_div_x;
    logic            w_div_clamped;
    logic [2:0]      w_div_cmd;
    tbc_pkg::t_geom  w_div_geom;

    // curve -> lerp
    logic            w_crv_valid;
    logic            w_crv_ready;
    tbc_pkg::t_ratio w_crv_v;
    logic            w_crv_clamped;
    tbc_pkg::t_geom  w_crv_geom;

    logic            w_lrp_ready;

    // ratio = elapsed / duration, clamped to 1.0
    tbc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (w_div_ready),
        .i_item    (i_item),
        .o_valid   (w_div_valid),
        .i_ready   (w_crv_ready),
        .o_x       (w_div_x),
        .o_clamped (w_div_clamped),
        .o_command (w_div_cmd),
        .o_geom    (w_div_geom)
    );

    // easing curve value v in [0, 1.0]
    tbc_curve u_curve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_div_valid),
        .o_ready   (w_crv_ready),
        .i_x       (w_div_x),
        .i_clamped (w_div_clamped),
        .i_command (w_div_cmd),
        .i_geom    (w_div_geom),
        .o_valid   (w_crv_valid),
        .i_ready   (w_lrp_ready),
        .o_v       (w_crv_v),
        .o_clamped (w_crv_clamped),
        .o_geom    (w_crv_geom)
    );

    // start + (end - start) * v per axis; last stage is the output register
    tbc_lerp u_lerp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_crv_valid),
        .o_ready   (w_lrp_ready),
        .i_v       (w_crv_v),
        .i_clamped (w_crv_clamped),
        .i_geom    (w_crv_geom),
        .o_valid   (o_valid),
        .i_ready   (!i_stall),
        .o_item    (o_item)
    );

    assign o_stall = !w_div_ready;

`ifndef SYNTHESIS
    // with the result side open, the whole pipe advances
    a_open_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while result side is open");

    // a clamped item leaves the divider at exactly 1.0
    a_clamp_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid && w_div_clamped) |-> (w_div_x == tbc_pkg::ONE))
        else $error("clamped ratio is not 1.0");

    // ratio and curve value never exceed 1.0
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid |-> (w_div_x <= tbc_pkg::ONE))
        else $error("ratio above 1.0");

    a_curve_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crv_valid |-> (w_crv_v <= tbc_pkg::ONE))
        else $error("curve value above 1.0");
`endif

endmodule
`default_nettype wire

// File: verif/eased_tween_by_curve_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// eased_tween_by_curve_unit_tb
// Self-checking bench: directed corners, then random tweens under back-pressure.
// ============================================================================
//
// Every accepted input item is run through a local predictor. The predictor
// computes the progress ratio, the easing curve and the per-axis
// interpolation. The prediction is queued, and each result item taken from
// the block is checked field by field against the oldest queued prediction.
// ============================================================================

class tween_scoreboard;

    localparam longint unsigned ONE_FX = longint'(1) << tbc_pkg::FRAC_BITS;
    localparam longint POS_HI = 64'sd2147483647;
    localparam longint POS_LO = -64'sd2147483648;

    tbc_pkg::t_out_item pending_positions[$];
    int unsigned        mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    function longint unsigned fx_sq(longint unsigned a);
        return (a * a) >> tbc_pkg::FRAC_BITS;
    endfunction

    function longint unsigned fx_cube(longint unsigned a);
        return (fx_sq(a) * a) >> tbc_pkg::FRAC_BITS;
    endfunction

    // Bounce out: pick the parabola by 11x, then ((22x - k)^2 / 64) + c.
    function longint unsigned bounce_value(longint unsigned x);
        longint unsigned k, c, p, d;
        if (11 * x < 4 * ONE_FX) begin
            k = 0;
            c = 0;
        end else if (11 * x < 8 * ONE_FX) begin
            k = 12 * ONE_FX;
            c = (3 * ONE_FX) >> 2;
        end else if (11 * x < 10 * ONE_FX) begin
            k = 18 * ONE_FX;
            c = (15 * ONE_FX) >> 4;
        end else begin
            k = 21 * ONE_FX;
            c = (63 * ONE_FX) >> 6;
        end
        p = 22 * x;
        d = (p >= k) ? p - k : k - p;
        return ((d * d) >> (tbc_pkg::FRAC_BITS + 6)) + c;
    endfunction

    function longint unsigned ease_curve(logic [2:0] code, longint unsigned x);
        case (code)
            tbc_pkg::CRV_CUBIC_IN:   return fx_cube(x);
            tbc_pkg::CRV_CUBIC_OUT:  return ONE_FX - fx_cube(ONE_FX - x);
            tbc_pkg::CRV_QUAD_IN:    return fx_sq(x);
            tbc_pkg::CRV_QUAD_OUT:   return ONE_FX - fx_sq(ONE_FX - x);
            tbc_pkg::CRV_BOUNCE_OUT: return bounce_value(x);
            default:                 return 0;
        endcase
    endfunction

    // start + floor((end - start) * v / ONE), floor toward minus infinity
    function logic [31:0] lerp_axis(logic signed [31:0] s, logic signed [31:0] e,
                                    longint unsigned v);
        longint sl, dl, q, r;
        longint unsigned mag;
        sl = s;
        dl = e;
        dl = dl - sl;
        if (dl >= 0) begin
            mag = dl;
            mag = mag * v;
            q = mag >> tbc_pkg::FRAC_BITS;
        end else begin
            mag = -dl;
            mag = mag * v;
            q = (mag + ONE_FX - 1) >> tbc_pkg::FRAC_BITS;
            q = -q;
        end
        r = sl + q;
        if (r > POS_HI) r = POS_HI;
        if (r < POS_LO) r = POS_LO;
        return r[31:0];
    endfunction

    function tbc_pkg::t_out_item predict_tween(tbc_pkg::t_in_item it);
        longint unsigned el, du, x, v;
        tbc_pkg::t_out_item res;
        el = it.elapsed;
        du = it.duration;
        if (du == 0 || el > du) begin
            x = ONE_FX;
            res.ratio_clamped = 1'b1;
        end else begin
            x = (el << tbc_pkg::FRAC_BITS) / du;
            res.ratio_clamped = 1'b0;
        end
        v = ease_curve(it.command, x);
        res.pos_x = lerp_axis(it.start_x, it.end_x, v);
        res.pos_y = lerp_axis(it.start_y, it.end_y, v);
        res.pos_z = lerp_axis(it.start_z, it.end_z, v);
        return res;
    endfunction

    function void note_input(tbc_pkg::t_in_item it);
        pending_positions.push_back(predict_tween(it));
    endfunction

    function void check_result(tbc_pkg::t_out_item got);
        tbc_pkg::t_out_item exp_res;
        if (pending_positions.size() == 0) begin
            if (mismatch_count < 10)
                $display("unexpected result: x=%h y=%h z=%h clamp=%b",
                         got.pos_x, got.pos_y, got.pos_z, got.ratio_clamped);
            mismatch_count++;
            return;
        end
        exp_res = pending_positions.pop_front();
        if (got.pos_x !== exp_res.pos_x || got.pos_y !== exp_res.pos_y ||
            got.pos_z !== exp_res.pos_z ||
            got.ratio_clamped !== exp_res.ratio_clamped) begin
            if (mismatch_count < 10)
                $display("bad result: exp x=%h y=%h z=%h clamp=%b got x=%h y=%h z=%h clamp=%b",
                         exp_res.pos_x, exp_res.pos_y, exp_res.pos_z,
                         exp_res.ratio_clamped, got.pos_x, got.pos_y, got.pos_z,
                         got.ratio_clamped);
            mismatch_count++;
        end
    endfunction

    function int unsigned pending();
        return pending_positions.size();
    endfunction

endclass

module eased_tween_by_curve_unit_tb;

    localparam real CLK_PERIOD      = 8.0;
    localparam int  PIPE_LATENCY    = tbc_pkg::FRAC_BITS + 8;
    localparam int  ITEMS_PER_PHASE = 400;
    // Longest quiet stretch tolerated: long stall runs plus a full pipe fill
    localparam int  WATCHDOG_LIMIT  = 4000;

    // Curve codes the package leaves unnamed: all mean "no curve"
    localparam logic [2:0] CRV_NONE = 3'd0;
    localparam logic [2:0] CRV_RSV6 = 3'd6;
    localparam logic [2:0] CRV_RSV7 = 3'd7;

    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] P_TEN = 32'sh000A_0000;   // 10.0 in Q16.16

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    tbc_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_stall;
    tbc_pkg::t_out_item o_item;

    tween_scoreboard tween_sb;

    int send_idle_pct;      // chance per cycle that the sender holds off
    int recv_stall_pct;     // chance per cycle that the receiver stalls
    int quiet_cycles;

    eased_tween_by_curve_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Input monitor: predict at the edge where the item is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            tween_sb.note_input(i_item);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tween_sb.check_result(o_item);
    end

    // Watchdog: counts cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic tbc_pkg::t_in_item make_item(
        logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
        logic signed [31:0] ex, logic signed [31:0] ey, logic signed [31:0] ez,
        logic [15:0] el, logic [15:0] du, logic [2:0] cmd);
        tbc_pkg::t_in_item it;
        it.start_x  = sx;
        it.start_y  = sy;
        it.start_z  = sz;
        it.end_x    = ex;
        it.end_y    = ey;
        it.end_z    = ez;
        it.elapsed  = el;
        it.duration = du;
        it.command  = cmd;
        return it;
    endfunction

    // Coordinates: mostly full-range, with extremes and small values mixed in
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] c;
        case ($urandom_range(7))
            0: c = P_MAX;
            1: c = P_MIN;
            2: begin
                c = $urandom_range(2000);
                c = c - 1000;
            end
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // Mostly running tweens (elapsed <= duration) with a real curve; the rest
    // are finished tweens, zero durations and unknown curve codes.
    function automatic tbc_pkg::t_in_item rand_item();
        logic [15:0] el, du;
        logic [2:0]  cmd;
        case ($urandom_range(9))
            0: begin
                du = 16'd0;
                el = $urandom;
            end
            1: begin
                du = $urandom_range(65534);
                el = $urandom_range(65535, du + 1);
            end
            2: begin
                du = $urandom_range(16, 1);
                el = $urandom_range(du);
            end
            default: begin
                du = $urandom_range(65535, 1);
                el = $urandom_range(du);
            end
        endcase
        if ($urandom_range(4) == 0)
            cmd = $urandom_range(7);
        else
            cmd = $urandom_range(tbc_pkg::CRV_BOUNCE_OUT, tbc_pkg::CRV_CUBIC_IN);
        return make_item(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), el, du, cmd);
    endfunction

    // Drive one item: optional idle cycles, then hold it until accepted.
    // Valid stays high after acceptance, so back-to-back items never glitch.
    task automatic send_item(input tbc_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic run_directed();
        // basic curves over a 10.0 span
        send_item(make_item(0, 0, 0, P_TEN, -P_TEN, P_TEN, 16'd0, 16'd100,
                            tbc_pkg::CRV_CUBIC_IN));
        send_item(make_item(0, 0, 0, P_TEN, -P_TEN, P_TEN, 16'd50, 16'd100,
                            tbc_pkg::CRV_CUBIC_IN));
        send_item(make_item(0, P_TEN, 0, P_TEN, 0, -P_TEN, 16'd1, 16'd3,
                            tbc_pkg::CRV_CUBIC_OUT));
        send_item(make_item(0, 0, P_TEN, P_TEN, P_TEN, 0, 16'd65534, 16'd65535,
                            tbc_pkg::CRV_QUAD_IN));
        send_item(make_item(P_TEN, 0, 0, 0, P_TEN, P_TEN, 16'd1, 16'd65535,
                            tbc_pkg::CRV_QUAD_OUT));
        // bounce: both sides of every segment edge, then the end point
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd4, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd5, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd8, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd9, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd10, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        // elapsed equal to duration: full ratio, not flagged
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd11, 16'd11,
                            tbc_pkg::CRV_BOUNCE_OUT));
        // zero duration
        send_item(make_item(0, 0, 0, P_TEN, P_TEN, -P_TEN, 16'd0, 16'd0,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(P_MIN, 0, P_MAX, P_MAX, 0, P_MIN, 16'd65535, 16'd0,
                            tbc_pkg::CRV_CUBIC_OUT));
        send_item(make_item(P_MIN, P_MAX, 0, P_MAX, P_MIN, 0, 16'd65535, 16'd65535,
                            tbc_pkg::CRV_QUAD_IN));
        // elapsed beyond duration
        send_item(make_item(P_MAX, P_MIN, -1, P_MIN, P_MAX, 1, 16'd65535, 16'd65534,
                            tbc_pkg::CRV_QUAD_OUT));
        // unknown curve codes hold the start position
        send_item(make_item(P_TEN, -P_TEN, 1, P_MAX, P_MIN, 0, 16'd3, 16'd7, CRV_NONE));
        send_item(make_item(P_MIN, P_MAX, -1, 0, 0, 0, 16'd3, 16'd7, CRV_RSV6));
        send_item(make_item(P_MAX, 0, P_MIN, P_MIN, P_MAX, P_MAX, 16'd0, 16'd0, CRV_RSV7));
        // widest spans in both directions, fractional results (floor checks)
        send_item(make_item(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, 16'd1, 16'd2,
                            tbc_pkg::CRV_CUBIC_IN));
        send_item(make_item(P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN, 16'd1, 16'd2,
                            tbc_pkg::CRV_QUAD_OUT));
        send_item(make_item(-1, 1, 0, P_MIN, -1, -3, 16'd3, 16'd4,
                            tbc_pkg::CRV_BOUNCE_OUT));
        send_item(make_item(P_MAX, 0, -7, P_MAX, 7, 0, 16'd1, 16'd65535,
                            tbc_pkg::CRV_CUBIC_OUT));
    endtask

    initial begin
        int ph;
        tween_sb       = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_item         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Traffic phases: free flow, sparse sender, heavy stall, both light
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_item(rand_item());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain; the watchdog covers a result that never shows up
        while (tween_sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        if (tween_sb.mismatch_count == 0 && tween_sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
